/* rtl/lrars_pkg.sv */
`default_nettype none
package lrars_pkg;

  localparam logic [1:0] MODE_LOAD   = 2'd0;
  localparam logic [1:0] MODE_ADD    = 2'd1;
  localparam logic [1:0] MODE_QUERY  = 2'd2;
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  localparam logic [10:0] SIZE_RESET = 11'd1024;

  typedef struct packed {
    logic [1:0]         mode;
    logic [10:0]        range_low;
    logic [10:0]        range_high;
    logic signed [31:0] value;
  } cmd_t;

  typedef struct packed {
    logic signed [31:0] range_sum;
    logic               range_error;
  } result_t;

endpackage
`default_nettype wire

/* rtl/lazy_range_add_range_sum_tree_core.sv */
// Range add / range sum store, kept as two Fenwick trees in two RAMs (one read-modify-write
// port each), walked by a single sequencer and one shared 32x32 multiplier.
// Each tree level is a RAM read, then an accumulate or a write back.
// One transaction at a time; busy stays high until the walk ends. The result strobe lasts
// one cycle and the receiver cannot stall it.
// Reset: synchronous; then a clearing pass over all MAX_ELEMENTS+1 RAM words with busy high.
`default_nettype none
module lazy_range_add_range_sum_tree_core
  import lrars_pkg::*;
#(
  parameter int MAX_ELEMENTS = 1024
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire cmd_t        cmd,
  output logic             done,
  output result_t          result,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [10:0] cfg_data
);

  localparam int AW = $clog2(MAX_ELEMENTS + 1);
  localparam int IW = $clog2(MAX_ELEMENTS) + 2;
  localparam logic [IW-1:0] IMAX = IW'(MAX_ELEMENTS);
  localparam logic [AW-1:0] AMAX = AW'(MAX_ELEMENTS);

  localparam logic [3:0] S_CLR  = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_PRD  = 4'd2;
  localparam logic [3:0] S_PACC = 4'd3;
  localparam logic [3:0] S_PMUL = 4'd4;
  localparam logic [3:0] S_PFIN = 4'd5;
  localparam logic [3:0] S_UMUL = 4'd6;
  localparam logic [3:0] S_URD  = 4'd7;
  localparam logic [3:0] S_UWR  = 4'd8;

  logic [3:0]    state;
  logic [1:0]    ph;
  logic [1:0]    op;
  logic [IW-1:0] idx, lo, hi, pos, lowbit;
  logic [AW-1:0] clr_idx;
  logic [31:0]   s1, s2, acc, amt, dlt, prod, val, mul_a, t;
  logic [10:0]   size;
  logic [31:0]   used, a32, b32;
  logic          ok, load_ok;

  logic [31:0]   mem1 [0:MAX_ELEMENTS];
  logic [31:0]   mem2 [0:MAX_ELEMENTS];
  logic [31:0]   rd1, rd2;
  logic          we;
  logic [AW-1:0] addr;
  logic [31:0]   wd1, wd2;

  assign busy      = (state != S_IDLE);
  assign cfg_ready = 1'b1;

  always_comb begin
    used    = (32'(size) > 32'(MAX_ELEMENTS)) ? 32'(MAX_ELEMENTS) : 32'(size);
    a32     = 32'(cmd.range_low);
    b32     = 32'(cmd.range_high);
    ok      = (a32 >= 32'd1) && (a32 <= b32) && (b32 <= used);
    load_ok = (a32 >= 32'd1) && (a32 <= used);
    lowbit  = idx & (~idx + IW'(1));
    case (ph)
      2'd0:    pos = hi;
      2'd1:    pos = lo - IW'(1);
      2'd2:    pos = lo - IW'(1);
      default: pos = hi;
    endcase
    mul_a = (state == S_PMUL) ? s1 : ((ph == 2'd2) ? amt : (32'd0 - amt));
    t     = prod - s2;
    we    = (state == S_CLR) || (state == S_UWR);
    addr  = (state == S_CLR) ? clr_idx : idx[AW-1:0];
    wd1   = (state == S_CLR) ? 32'd0 : rd1 + dlt;
    wd2   = (state == S_CLR) ? 32'd0 : rd2 + prod;
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem1[addr] <= wd1;
      mem2[addr] <= wd2;
    end
    rd1 <= mem1[addr];
    rd2 <= mem2[addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      size <= SIZE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      size <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLR;
      clr_idx <= '0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_CLR: begin
          if (clr_idx == AMAX) state <= S_IDLE;
          clr_idx <= clr_idx + AW'(1);
        end
        S_IDLE: begin
          if (start) begin
            op  <= cmd.mode;
            val <= cmd.value;
            s1  <= '0;
            s2  <= '0;
            case (cmd.mode)
              MODE_LOAD: begin
                if (load_ok) begin
                  lo <= IW'(cmd.range_low); hi <= IW'(cmd.range_low);
                  idx <= IW'(cmd.range_low); ph <= 2'd0; state <= S_PRD;
                end
              end
              MODE_ADD: begin
                if (ok) begin
                  lo <= IW'(cmd.range_low); hi <= IW'(cmd.range_high);
                  amt <= cmd.value; ph <= 2'd2; state <= S_UMUL;
                end
              end
              MODE_QUERY: begin
                if (ok) begin
                  lo <= IW'(cmd.range_low); hi <= IW'(cmd.range_high);
                  idx <= IW'(cmd.range_high); ph <= 2'd0; state <= S_PRD;
                end else begin
                  result.range_sum   <= '0;
                  result.range_error <= 1'b1;
                  done               <= 1'b1;
                end
              end
              default: ;
            endcase
          end
        end
        S_PRD: begin
          state <= (idx == '0) ? S_PMUL : S_PACC;
        end
        S_PACC: begin
          s1    <= s1 + rd1;
          s2    <= s2 + rd2;
          idx   <= idx - lowbit;
          state <= S_PRD;
        end
        S_PMUL: begin
          prod  <= mul_a * 32'(pos);
          state <= S_PFIN;
        end
        S_PFIN: begin
          if (ph == 2'd0) begin
            acc   <= t;
            ph    <= 2'd1;
            idx   <= lo - IW'(1);
            s1    <= '0;
            s2    <= '0;
            state <= S_PRD;
          end else if (op == MODE_QUERY) begin
            result.range_sum   <= acc - t;
            result.range_error <= 1'b0;
            done               <= 1'b1;
            state              <= S_IDLE;
          end else begin
            amt   <= val - (acc - t);
            ph    <= 2'd2;
            state <= S_UMUL;
          end
        end
        S_UMUL: begin
          dlt   <= mul_a;
          prod  <= mul_a * 32'(pos);
          idx   <= (ph == 2'd2) ? lo : hi + IW'(1);
          state <= S_URD;
        end
        S_URD: begin
          if (idx > IMAX) begin
            if (ph == 2'd2) begin
              ph    <= 2'd3;
              state <= S_UMUL;
            end else begin
              state <= S_IDLE;
            end
          end else begin
            state <= S_UWR;
          end
        end
        S_UWR: begin
          idx   <= idx + lowbit;
          state <= S_URD;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_done_src: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(start) && $past(state) == S_IDLE) || $past(state) == S_PFIN)
    else $error("result strobe without a finished transaction");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (done && result.range_error) |-> result.range_sum == '0)
    else $error("rejected query with non-zero sum");

  a_wr_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_UWR) |-> idx <= IMAX && idx != '0)
    else $error("tree write out of range");

  a_rd_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_PACC) |-> idx <= IMAX)
    else $error("prefix walk out of range");

endmodule
`default_nettype wire
